// ===== rtl/opl_pkg.sv =====
// opl_pkg: shared types, codes and defaults for the ordered page list block
// no dependencies; used by the front, the back, the top level and the testbench
`default_nettype none

package opl_pkg;

  // default pool size and queue depth
  localparam int SLOTS_DEF   = 1024;
  localparam int QUEUE_DEPTH = 2;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int PAGE_W  = 32;
  localparam int SLOT_W  = 10;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 11;

  // page value written into an evicted slot
  localparam logic [PAGE_W-1:0] PAGE_EVICTED = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EVICT   = 2'd1,
    CMD_RECYCLE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NOFREE = 2'd2,
    STAT_WRONG  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SS_FREE     = 2'd0,
    SS_LINKED   = 2'd1,
    SS_DETACHED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PAGE_W-1:0] page_index;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  taken_slot;
    logic [SLOT_W-1:0]  head_slot;
    logic [SLOT_W-1:0]  tail_slot;
    logic               list_empty;
    logic [COUNT_W-1:0] list_count;
    logic [COUNT_W-1:0] free_count;
  } out_item_t;

  // classified command as it sits in the command queue
  typedef struct packed {
    cmd_t              op;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] slot;
    logic              in_range;
  } dec_t;

endpackage

`default_nettype wire

// ===== rtl/opl_fifo.sv =====
// opl_fifo: small register queue used between the front, back and result port
// depends on nothing but the payload type handed in
`default_nettype none

module opl_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire T     wdata,
  output logic      full,
  input  wire logic pop,
  output T          rdata,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/opl_front.sv =====
// opl_front: accepts command beats and classifies them for the command queue
// depends on opl_pkg
`default_nettype none

module opl_front #(
  parameter int SLOTS = opl_pkg::SLOTS_DEF
) (
  input  wire logic             push,
  input  wire opl_pkg::in_item_t item,
  output logic                  full,
  input  wire logic             q_full,
  input  wire logic             clearing,
  output logic                  q_push,
  output opl_pkg::dec_t         q_data
);

  logic [31:0] slot_w;

  assign slot_w = 32'(item.slot);

  // held off while the queue is full or the link memories are swept
  assign full   = q_full || clearing;
  assign q_push = push && !full;

  always_comb begin
    q_data.op       = opl_pkg::cmd_t'(item.command);
    q_data.page     = item.page_index;
    q_data.slot     = item.slot;
    q_data.in_range = (slot_w < 32'(SLOTS));
  end

endmodule

`default_nettype wire

// ===== rtl/opl_back.sv =====
// opl_back: link memories, list and pool registers and the command sequencer
// depends on opl_pkg
`default_nettype none

module opl_back #(
  parameter int SLOTS = opl_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire opl_pkg::dec_t q_head,
  output logic               q_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output opl_pkg::out_item_t res_data,
  output logic               clearing
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

  // memories
  logic [LW-1:0]             next_mem [SLOTS];
  logic [LW-1:0]             prev_mem [SLOTS];
  opl_pkg::slot_st_t         st_mem   [SLOTS];
  logic [opl_pkg::PAGE_W-1:0] page_mem [SLOTS];

  logic                       nx_we;
  logic [SW-1:0]              nx_wa;
  logic [LW-1:0]              nx_wd;
  logic [SW-1:0]              nx_ra;
  logic [LW-1:0]              nx_rd;
  logic                       pv_we;
  logic [SW-1:0]              pv_wa;
  logic [LW-1:0]              pv_wd;
  logic [SW-1:0]              pv_ra;
  logic [LW-1:0]              pv_rd;
  logic                       st_we;
  logic [SW-1:0]              st_wa;
  opl_pkg::slot_st_t          st_wd;
  logic [SW-1:0]              st_ra;
  opl_pkg::slot_st_t          st_rd;
  logic                       pg_we;
  logic [SW-1:0]              pg_wa;
  logic [opl_pkg::PAGE_W-1:0] pg_wd;

  // control and list registers
  opl_pkg::bk_state_t state;
  opl_pkg::bk_state_t state_next;
  logic [SW-1:0]      clr_idx;
  opl_pkg::dec_t      cur;
  logic [LW-1:0]      list_head;
  logic [LW-1:0]      list_head_next;
  logic [LW-1:0]      list_tail;
  logic [LW-1:0]      list_tail_next;
  logic [LW-1:0]      pool_head;
  logic [LW-1:0]      pool_head_next;
  logic [LW-1:0]      linked_count;
  logic [LW-1:0]      linked_count_next;
  logic [LW-1:0]      pool_count;
  logic [LW-1:0]      pool_count_next;

  logic               issue;
  logic               ins_full;
  logic               ins_nofree;
  logic [SW-1:0]      q_addr;
  logic [SW-1:0]      cur_addr;
  logic [SW-1:0]      pool_idx;
  logic [31:0]        q_slot_w;
  logic [31:0]        cur_slot_w;
  opl_pkg::status_t   status;
  logic [LW-1:0]      taken;
  logic [31:0]        taken_w;
  logic [31:0]        head_w;
  logic [31:0]        tail_w;
  logic [31:0]        lcnt_w;
  logic [31:0]        fcnt_w;
  logic               empty_next;

  assign q_slot_w   = 32'(q_head.slot);
  assign cur_slot_w = 32'(cur.slot);
  assign q_addr     = q_slot_w[SW-1:0];
  assign cur_addr   = cur_slot_w[SW-1:0];
  assign pool_idx   = pool_head[SW-1:0];
  assign ins_full   = (32'(linked_count) >= 32'(SLOTS));
  assign ins_nofree = (32'(pool_head) >= 32'(SLOTS)) || (pool_count == '0);
  assign issue      = (state == opl_pkg::BK_IDLE) && !q_empty && !res_full;
  assign clearing   = (state == opl_pkg::BK_CLEAR);

  // memory ports
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    nx_rd <= next_mem[nx_ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    pv_rd <= prev_mem[pv_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    st_rd <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (pg_we) begin
      page_mem[pg_wa] <= pg_wd;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      opl_pkg::BK_CLEAR: begin
        if (clr_idx == SW'(SLOTS - 1)) begin
          state_next = opl_pkg::BK_IDLE;
        end
      end
      opl_pkg::BK_IDLE: begin
        if (issue) begin
          state_next = opl_pkg::BK_EXEC;
        end
      end
      opl_pkg::BK_EXEC: begin
        state_next = opl_pkg::BK_IDLE;
      end
      default: begin
        state_next = opl_pkg::BK_IDLE;
      end
    endcase
  end

  // memory controls, register updates and result
  always_comb begin
    nx_we = 1'b0;
    nx_wa = '0;
    nx_wd = '0;
    nx_ra = pool_idx;
    pv_we = 1'b0;
    pv_wa = '0;
    pv_wd = '0;
    pv_ra = q_addr;
    st_we = 1'b0;
    st_wa = '0;
    st_wd = opl_pkg::SS_FREE;
    st_ra = q_addr;
    pg_we = 1'b0;
    pg_wa = '0;
    pg_wd = '0;
    q_pop    = 1'b0;
    res_push = 1'b0;
    list_head_next    = list_head;
    list_tail_next    = list_tail;
    pool_head_next    = pool_head;
    linked_count_next = linked_count;
    pool_count_next   = pool_count;
    status = opl_pkg::STAT_OK;
    taken  = '0;
    case (state)
      opl_pkg::BK_CLEAR: begin
        // slot i links to i plus one, all slots free
        nx_we = 1'b1;
        nx_wa = clr_idx;
        nx_wd = LW'(clr_idx) + LW'(1);
        st_we = 1'b1;
        st_wa = clr_idx;
        st_wd = opl_pkg::SS_FREE;
      end
      opl_pkg::BK_IDLE: begin
        if (issue) begin
          q_pop = 1'b1;
          case (q_head.op)
            opl_pkg::CMD_INSERT: begin
              if (!ins_full && !ins_nofree) begin
                // fetch the new pool top, link the slot behind the tail
                nx_ra = pool_idx;
                if (list_tail != NULL_LINK) begin
                  nx_we = 1'b1;
                  nx_wa = list_tail[SW-1:0];
                  nx_wd = pool_head;
                end
                pv_we = 1'b1;
                pv_wa = pool_idx;
                pv_wd = list_tail;
                st_we = 1'b1;
                st_wa = pool_idx;
                st_wd = opl_pkg::SS_LINKED;
                pg_we = 1'b1;
                pg_wa = pool_idx;
                pg_wd = q_head.page;
              end
            end
            opl_pkg::CMD_EVICT: begin
              nx_ra = q_addr;
              pv_ra = q_addr;
              st_ra = q_addr;
            end
            opl_pkg::CMD_RECYCLE: begin
              st_ra = q_addr;
            end
            default: begin
            end
          endcase
        end
      end
      opl_pkg::BK_EXEC: begin
        res_push = 1'b1;
        case (cur.op)
          opl_pkg::CMD_INSERT: begin
            if (ins_full) begin
              status = opl_pkg::STAT_FULL;
            end else if (ins_nofree) begin
              status = opl_pkg::STAT_NOFREE;
            end else begin
              nx_we = 1'b1;
              nx_wa = pool_idx;
              nx_wd = NULL_LINK;
              pool_head_next    = nx_rd;
              pool_count_next   = pool_count - LW'(1);
              linked_count_next = linked_count + LW'(1);
              list_tail_next    = pool_head;
              if (list_head == NULL_LINK) begin
                list_head_next = pool_head;
              end
              taken = pool_head;
            end
          end
          opl_pkg::CMD_EVICT: begin
            if (!cur.in_range || (st_rd != opl_pkg::SS_LINKED)) begin
              status = opl_pkg::STAT_WRONG;
            end else begin
              // splice neighbors around the slot
              if (pv_rd != NULL_LINK) begin
                nx_we = 1'b1;
                nx_wa = pv_rd[SW-1:0];
                nx_wd = nx_rd;
              end else begin
                list_head_next = nx_rd;
              end
              if (nx_rd != NULL_LINK) begin
                pv_we = 1'b1;
                pv_wa = nx_rd[SW-1:0];
                pv_wd = pv_rd;
              end else begin
                list_tail_next = pv_rd;
              end
              if (linked_count != '0) begin
                linked_count_next = linked_count - LW'(1);
              end
              st_we = 1'b1;
              st_wa = cur_addr;
              st_wd = opl_pkg::SS_DETACHED;
              pg_we = 1'b1;
              pg_wa = cur_addr;
              pg_wd = opl_pkg::PAGE_EVICTED;
            end
          end
          opl_pkg::CMD_RECYCLE: begin
            if (!cur.in_range || (st_rd != opl_pkg::SS_DETACHED)) begin
              status = opl_pkg::STAT_WRONG;
            end else begin
              nx_we = 1'b1;
              nx_wa = cur_addr;
              nx_wd = pool_head;
              st_we = 1'b1;
              st_wa = cur_addr;
              st_wd = opl_pkg::SS_FREE;
              pool_head_next  = LW'(cur_addr);
              pool_count_next = pool_count + LW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result shows the state after the command
  assign empty_next = (list_head_next == NULL_LINK);
  assign taken_w    = 32'(taken);
  assign head_w     = empty_next ? '0 : 32'(list_head_next);
  assign tail_w     = empty_next ? '0 : 32'(list_tail_next);
  assign lcnt_w     = 32'(linked_count_next);
  assign fcnt_w     = 32'(pool_count_next);

  always_comb begin
    res_data.status     = status;
    res_data.taken_slot = taken_w[opl_pkg::SLOT_W-1:0];
    res_data.head_slot  = head_w[opl_pkg::SLOT_W-1:0];
    res_data.tail_slot  = tail_w[opl_pkg::SLOT_W-1:0];
    res_data.list_empty = empty_next;
    res_data.list_count = lcnt_w[opl_pkg::COUNT_W-1:0];
    res_data.free_count = fcnt_w[opl_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= opl_pkg::BK_CLEAR;
      clr_idx      <= '0;
      list_head    <= NULL_LINK;
      list_tail    <= NULL_LINK;
      pool_head    <= '0;
      linked_count <= '0;
      pool_count   <= LW'(SLOTS);
    end else begin
      state        <= state_next;
      if (state == opl_pkg::BK_CLEAR) begin
        clr_idx <= clr_idx + SW'(1);
      end
      list_head    <= list_head_next;
      list_tail    <= list_tail_next;
      pool_head    <= pool_head_next;
      linked_count <= linked_count_next;
      pool_count   <= pool_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ordered_page_list_with_free_pool.sv =====
// ordered page list with free pool: top level, front, command queue, back, result queue
// a beat passes command queue, back issue and execute states and result queue
//   before empty goes low; one command at a time: issue reads the link memories
//   (an insert also links there), execute writes them; one write port per memory,
//   one read port per link and state memory; reset: synchronous, then the back
//   sweeps next-link and state memories (full high) before the first beat is taken
// depends on opl_pkg, opl_front, opl_fifo, opl_back
`default_nettype none

module ordered_page_list_with_free_pool #(
  parameter int SLOTS  = opl_pkg::SLOTS_DEF,
  parameter int QDEPTH = opl_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command side
  input  wire logic              push,
  input  wire opl_pkg::in_item_t item,
  output logic                   full,
  // result side
  output logic                   empty,
  input  wire logic              pop,
  output opl_pkg::out_item_t     result
);

  // front to command queue
  logic          fq_push;
  opl_pkg::dec_t fq_data;
  logic          fq_full;

  // command queue to back
  logic          cq_empty;
  logic          cq_pop;
  opl_pkg::dec_t cq_head;

  // back to result queue
  logic               rq_push;
  opl_pkg::out_item_t rq_data;
  logic               rq_full;

  logic clearing;

  // classify the command and check the slot range
  opl_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .push    (push),
    .item    (item),
    .full    (full),
    .q_full  (fq_full),
    .clearing(clearing),
    .q_push  (fq_push),
    .q_data  (fq_data)
  );

  // short queue that decouples the front from the sequencer
  opl_fifo #(
    .DEPTH(QDEPTH),
    .T    (opl_pkg::dec_t)
  ) u_cmdq (
    .clk  (clk),
    .rst  (rst),
    .push (fq_push),
    .wdata(fq_data),
    .full (fq_full),
    .pop  (cq_pop),
    .rdata(cq_head),
    .empty(cq_empty)
  );

  // link memories and list bookkeeping, one command at a time
  opl_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (cq_empty),
    .q_head  (cq_head),
    .q_pop   (cq_pop),
    .res_full(rq_full),
    .res_push(rq_push),
    .res_data(rq_data),
    .clearing(clearing)
  );

  // result beats wait here so the back keeps working while pop is low until it fills
  opl_fifo #(
    .DEPTH(QDEPTH),
    .T    (opl_pkg::out_item_t)
  ) u_resq (
    .clk  (clk),
    .rst  (rst),
    .push (rq_push),
    .wdata(rq_data),
    .full (rq_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for the ordered page list with free pool: directed list and pool cases,
// a fill to capacity under result backpressure, then biased random command traffic
// depends on opl_pkg and ordered_page_list_with_free_pool
module testbench;

  localparam int SLOTS = opl_pkg::SLOTS_DEF;
  localparam int COUNT_W = opl_pkg::COUNT_W;
  localparam int SLOT_W = opl_pkg::SLOT_W;
  localparam int PAGE_W = opl_pkg::PAGE_W;
  localparam logic [COUNT_W-1:0] NIL = COUNT_W'(SLOTS);  // null link code, one past the last slot
  localparam int CYCLE_LIMIT = 400000;          // includes the clearing sweep after reset
  localparam int DRAIN_CYCLES = 16;             // wait after the last report for stray beats
  localparam int FILL_HOLD = 400;               // long receiver hold-off during the fill
  localparam int RANDOM_ITEMS = 40;

  logic clk = 1'b0;
  logic rst;
  logic push;
  opl_pkg::in_item_t item;
  logic full;
  logic empty;
  logic pop;
  opl_pkg::out_item_t result;

  ordered_page_list_with_free_pool dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .item(item),
    .full(full),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the slot pool: both linked structures and the per-slot state
  logic [COUNT_W-1:0] shadow_next [0:SLOTS-1];
  logic [COUNT_W-1:0] shadow_prev [0:SLOTS-1];
  opl_pkg::slot_st_t shadow_state [0:SLOTS-1];
  logic [COUNT_W-1:0] shadow_head;
  logic [COUNT_W-1:0] shadow_tail;
  logic [COUNT_W-1:0] shadow_pool_top;
  int unsigned shadow_linked;
  int unsigned shadow_free;

  // reports still owed by the block, oldest first
  opl_pkg::out_item_t pending_reports [$];

  int mismatches = 0;
  int beats_seen = 0;
  int sent_count = 0;
  int result_hold = 0;      // set by a test to make the receiver stall for that many cycles
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;

  function automatic void clear_shadow_lists();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_next[i] = COUNT_W'(i + 1);
      shadow_prev[i] = NIL;
      shadow_state[i] = opl_pkg::SS_FREE;
    end
    shadow_head = NIL;
    shadow_tail = NIL;
    shadow_pool_top = '0;
    shadow_linked = 0;
    shadow_free = SLOTS;
  endfunction

  // applies one command to the shadow lists and returns the report it produces
  function automatic opl_pkg::out_item_t apply_command(opl_pkg::in_item_t c);
    opl_pkg::out_item_t r;
    logic [COUNT_W-1:0] s;
    logic [COUNT_W-1:0] p;
    logic [COUNT_W-1:0] n;
    r = '0;
    r.status = opl_pkg::STAT_OK;
    s = {1'b0, c.slot};
    case (opl_pkg::cmd_t'(c.command))
      opl_pkg::CMD_INSERT: begin
        // both capacity checks come before a slot is taken
        if (shadow_linked >= SLOTS) begin
          r.status = opl_pkg::STAT_FULL;
        end else if (shadow_pool_top >= NIL || shadow_free == 0) begin
          r.status = opl_pkg::STAT_NOFREE;
        end else begin
          s = shadow_pool_top;
          shadow_pool_top = shadow_next[s];
          shadow_free--;
          shadow_state[s] = opl_pkg::SS_LINKED;
          shadow_next[s] = NIL;
          if (shadow_tail != NIL) begin
            shadow_next[shadow_tail] = s;
            shadow_prev[s] = shadow_tail;
          end else begin
            shadow_head = s;
            shadow_prev[s] = NIL;
          end
          shadow_tail = s;
          shadow_linked++;
          r.taken_slot = s[SLOT_W-1:0];
        end
      end
      opl_pkg::CMD_EVICT: begin
        if (s >= NIL || shadow_state[s] != opl_pkg::SS_LINKED) begin
          r.status = opl_pkg::STAT_WRONG;
        end else begin
          p = shadow_prev[s];
          n = shadow_next[s];
          if (p != NIL) shadow_next[p] = n;
          else shadow_head = n;
          if (n != NIL) shadow_prev[n] = p;
          else shadow_tail = p;
          if (shadow_linked > 0) shadow_linked--;
          shadow_next[s] = NIL;
          shadow_prev[s] = NIL;
          shadow_state[s] = opl_pkg::SS_DETACHED;
        end
      end
      opl_pkg::CMD_RECYCLE: begin
        if (s >= NIL || shadow_state[s] != opl_pkg::SS_DETACHED) begin
          r.status = opl_pkg::STAT_WRONG;
        end else begin
          shadow_next[s] = shadow_pool_top;
          shadow_prev[s] = NIL;
          shadow_pool_top = s;
          shadow_free++;
          shadow_state[s] = opl_pkg::SS_FREE;
        end
      end
      default: ;  // unused command: no change, status ok
    endcase
    r.list_empty = (shadow_head == NIL);
    r.head_slot = r.list_empty ? '0 : shadow_head[SLOT_W-1:0];
    r.tail_slot = r.list_empty ? '0 : shadow_tail[SLOT_W-1:0];
    r.list_count = COUNT_W'(shadow_linked);
    r.free_count = COUNT_W'(shadow_free);
    return r;
  endfunction

  // any slot in the given state, searched from a random start; null if none
  function automatic logic [COUNT_W-1:0] find_slot(opl_pkg::slot_st_t want);
    int start;
    logic [COUNT_W-1:0] s;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      s = COUNT_W'((start + k) % SLOTS);
      if (shadow_state[s] == want) return s;
    end
    return NIL;
  endfunction

  // sends one command beat; push stays high when the next beat follows with no gap
  task automatic send_command(opl_pkg::cmd_t op, logic [PAGE_W-1:0] page,
                              logic [SLOT_W-1:0] slot);
    opl_pkg::in_item_t beat;
    int gap;
    beat.command = op;
    beat.page_index = page;
    beat.slot = slot;
    // every 40 beats decide whether the sender runs without gaps for a while
    if (sent_count % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= beat;
    do @(posedge clk); while (full);
    // accepted at this edge: the report it owes goes to the back of the line
    pending_reports.push_back(apply_command(beat));
    sent_count++;
  endtask

  // evict a slot that is linked, or a random one if the list is empty
  task automatic evict_linked();
    logic [COUNT_W-1:0] s;
    s = find_slot(opl_pkg::SS_LINKED);
    case ($urandom_range(0, 3))
      0: if (shadow_head != NIL) s = shadow_head;
      1: if (shadow_tail != NIL) s = shadow_tail;
      default: ;
    endcase
    if (s == NIL) s = COUNT_W'($urandom_range(0, SLOTS - 1));
    send_command(opl_pkg::CMD_EVICT, $urandom(), s[SLOT_W-1:0]);
  endtask

  // recycle a detached slot, or a random one if none is detached
  task automatic recycle_detached();
    logic [COUNT_W-1:0] s;
    s = find_slot(opl_pkg::SS_DETACHED);
    if (s == NIL) s = COUNT_W'($urandom_range(0, SLOTS - 1));
    send_command(opl_pkg::CMD_RECYCLE, $urandom(), s[SLOT_W-1:0]);
  endtask

  // state right after reset, and commands on slots that are still free
  task automatic test_reset_view();
    send_command(opl_pkg::CMD_NONE, '1, '1);
    send_command(opl_pkg::CMD_EVICT, '0, '0);
    send_command(opl_pkg::CMD_RECYCLE, '1, '1);
  endtask

  // small list: evict from middle, head and tail, wrong-state cases, pool order
  task automatic test_list_ops();
    send_command(opl_pkg::CMD_INSERT, '0, '1);
    send_command(opl_pkg::CMD_INSERT, '1, '0);
    send_command(opl_pkg::CMD_INSERT, 32'h8000_0000, 10'h155);
    send_command(opl_pkg::CMD_INSERT, $urandom(), 10'h2aa);
    send_command(opl_pkg::CMD_EVICT, $urandom(), 10'd1);     // middle entry
    send_command(opl_pkg::CMD_EVICT, $urandom(), 10'd0);     // head entry
    send_command(opl_pkg::CMD_EVICT, $urandom(), 10'd3);     // tail entry
    send_command(opl_pkg::CMD_EVICT, $urandom(), 10'd1);     // already detached
    send_command(opl_pkg::CMD_RECYCLE, $urandom(), 10'd2);   // still linked
    send_command(opl_pkg::CMD_RECYCLE, $urandom(), 10'd1);
    send_command(opl_pkg::CMD_RECYCLE, $urandom(), 10'd0);
    send_command(opl_pkg::CMD_RECYCLE, $urandom(), 10'd0);   // already free
    send_command(opl_pkg::CMD_EVICT, $urandom(), 10'd2);     // last entry, list goes empty
    send_command(opl_pkg::CMD_RECYCLE, $urandom(), 10'd2);
    send_command(opl_pkg::CMD_RECYCLE, $urandom(), 10'd3);
    send_command(opl_pkg::CMD_NONE, $urandom(), 10'($urandom()));
    send_command(opl_pkg::CMD_INSERT, $urandom(), 10'($urandom()));
  endtask

  // fill every slot while the receiver holds off, then hit the full list and the empty pool
  task automatic test_fill_and_starve();
    result_hold = FILL_HOLD;
    while (shadow_linked < SLOTS && shadow_free > 0)
      send_command(opl_pkg::CMD_INSERT, $urandom(), 10'($urandom()));
    send_command(opl_pkg::CMD_INSERT, $urandom(), 10'($urandom()));   // list full
    send_command(opl_pkg::CMD_EVICT, $urandom(), shadow_head[SLOT_W-1:0]);
    send_command(opl_pkg::CMD_EVICT, $urandom(), shadow_tail[SLOT_W-1:0]);
    repeat (3) evict_linked();
    send_command(opl_pkg::CMD_INSERT, '1, 10'($urandom()));   // pool empty, slots detached
    recycle_detached();
    send_command(opl_pkg::CMD_INSERT, '0, 10'($urandom()));
  endtask

  // random traffic in phases that grow, shrink or hold the list level
  task automatic test_random_mix();
    int ins_w;
    int ev_w;
    int rec_w;
    int roll;
    logic [PAGE_W-1:0] page;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: begin ins_w = 55; ev_w = 20; rec_w = 15; end
          1: begin ins_w = 15; ev_w = 45; rec_w = 30; end
          default: begin ins_w = 35; ev_w = 30; rec_w = 25; end
        endcase
      end
      page = ($urandom_range(0, 15) == 0) ? {PAGE_W{1'($urandom())}} : $urandom();
      roll = $urandom_range(0, 99);
      if (roll < ins_w) begin
        send_command(opl_pkg::CMD_INSERT, page, 10'($urandom()));
      end else if (roll < ins_w + ev_w) begin
        evict_linked();
      end else if (roll < ins_w + ev_w + rec_w) begin
        recycle_detached();
      end else if (roll < 96) begin
        // noise: any command on any slot, mostly in the wrong state
        send_command(opl_pkg::cmd_t'($urandom_range(0, 3)), page, 10'($urandom()));
      end else begin
        send_command(opl_pkg::CMD_NONE, page, 10'($urandom()));
      end
    end
  endtask

  // result side: random stalls per beat, plus the long hold-off a test asks for
  initial begin : result_side
    int stall;
    int beats;
    beats = 0;
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      if (beats % 40 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      stall = receiver_steady ? 0 : $urandom_range(0, 7);
      if (result_hold > 0) begin
        stall = result_hold;
        result_hold = 0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      beats++;
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat %0d: %s expected %0d, got %0d", beats_seen, name, want, got);
    end
  endtask

  // every accepted result beat is checked against the oldest report owed
  always @(posedge clk) begin : result_check
    opl_pkg::out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("beat %0d: result with no report owed", beats_seen);
      end else begin
        want = pending_reports.pop_front();
        compare_field("status", want.status, result.status);
        compare_field("taken_slot", want.taken_slot, result.taken_slot);
        compare_field("head_slot", want.head_slot, result.head_slot);
        compare_field("tail_slot", want.tail_slot, result.tail_slot);
        compare_field("list_empty", want.list_empty, result.list_empty);
        compare_field("list_count", want.list_count, result.list_count);
        compare_field("free_count", want.free_count, result.free_count);
      end
      beats_seen++;
    end
  end

  // watchdog: the slowest legal run is far below this
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    clear_shadow_lists();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // the block sweeps its memories next; full holds off the first beat
    test_reset_view();
    test_list_ops();
    test_fill_and_starve();
    test_random_mix();
    push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // catch any stray beat after the last report
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
